// File: design/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// No dependencies; used by the top level, tcw_dp and tcw_ctrl.
package tcw_pkg;

    // Default geometry
    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Port widths
    localparam int IN_W   = 24;
    localparam int IN_UW  = 2;
    localparam int OUT_W  = 40;
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 4;

    // Function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;

    localparam logic [15:0] RESET_CELL = 16'h0F20;
    localparam logic [3:0]  FG_RESET   = 4'hF;
    localparam logic [3:0]  BG_RESET   = 4'h0;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_BG = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
        logic copy;
        logic fill;
        logic init;
        logic emit;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       rd_ok;
        logic       scroll;
        logic       copy_last;
        logic       cell_last;
        logic       out_free;
    } tcw_status_t;

endpackage

// File: design/text_console_character_writer.sv
// A put item passes S_IDLE (accept), S_EXEC and S_DONE, where the registered result is emitted
// (a read in range adds S_READ); the controller is back in S_IDLE as the result goes valid.
// One item is in flight, and a result not yet taken holds the next one back. A scroll adds an
// S_COPY sweep, S_DRAIN and an S_BLANK fill of the last row, and a clear an S_FILL sweep of
// every cell, set by the single RAM write port sweeping one cell a cycle. After reset the cell
// RAM is swept to 0x0F20 in S_INIT before the first item; reset is asynchronous, active low.
module text_console_character_writer #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // func[1:0]
    input  logic [tcw_pkg::IN_UW-1:0]  s_axis_tuser,
    // char_code[7:0], read_row[12:8], read_col[19:13], zero[23:20]
    input  logic [tcw_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_index[22:12], cell_data[38:23],
    // scrolled[39]
    output logic [tcw_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       cfg_we,
    input  logic [tcw_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [tcw_pkg::CFG_DW-1:0] cfg_wdata
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t st;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcw_dp #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_axis_tuser),
        .s_tdata   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .cmd       (cmd),
        .st        (st)
    );
endmodule

// File: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/tcw_dp.sv
// Datapath: screen RAM, cursor, color registers, sweep counter and result register.
// Depends on tcw_pkg and tcw_ram; driven by tcw_ctrl commands.
module tcw_dp #(
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tcw_pkg::IN_UW-1:0]   s_tuser,
    input  logic [tcw_pkg::IN_W-1:0]    s_tdata,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [tcw_pkg::CFG_DW-1:0]  cfg_wdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tcw_pkg::OUT_W-1:0]   m_tdata,
    input  tcw_pkg::tcw_cmd_t           cmd,
    output tcw_pkg::tcw_status_t        st
);
    import tcw_pkg::*;

    localparam int NCELL = ROWS * COLS;
    localparam int SPAN  = (ROWS - 1) * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam int XW    = $clog2(COLS);
    localparam int TXW   = $clog2(COLS + TAB_STOP);
    localparam int YW    = $clog2(ROWS);
    localparam int TYW   = $clog2(ROWS + 1);
    localparam int MW    = $clog2(TAB_STOP);

    // Latched item
    logic [1:0] func_reg;
    logic [7:0] code_reg;
    logic [4:0] rrow_reg;
    logic [6:0] rcol_reg;

    logic [XW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [MW-1:0]    mod_reg, mod_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic             wr_pend_reg;
    logic [AW-1:0]    wr_addr_reg;
    logic [3:0]       fg_reg, bg_reg;
    logic [15:0]      cell_reg;
    logic             scrolled_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;

    logic [TXW-1:0] xt;
    logic [TYW-1:0] yt;
    logic [MW-1:0]  mt;
    logic           put_wr;
    logic           scroll;
    logic [AW-1:0]  cur_addr;
    logic [AW-1:0]  cell_addr;
    logic           rd_ok;
    logic [15:0]    blank;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;

    assign blank     = {bg_reg, fg_reg, BLANK_CHAR};
    assign cur_addr  = AW'(y_reg * COLS + x_reg);
    assign cell_addr = AW'(rrow_reg * COLS + rcol_reg);
    assign rd_ok     = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLS);

    // Cursor motion for a put-character item
    always_comb
    begin
        xt     = TXW'(x_reg);
        yt     = TYW'(y_reg);
        mt     = mod_reg;
        put_wr = 1'b0;
        case (code_reg)
            CH_BS:
            begin
                if (x_reg != '0)
                begin
                    xt = TXW'(x_reg) - TXW'(1);
                    mt = (mod_reg == '0) ? MW'(TAB_STOP - 1) : mod_reg - MW'(1);
                end
            end
            CH_TAB:
            begin
                xt = TXW'(x_reg) + TXW'(TAB_STOP) - TXW'(mod_reg);
                mt = '0;
            end
            CH_CR:
            begin
                xt = '0;
                mt = '0;
            end
            CH_LF:
            begin
                xt = '0;
                yt = yt + TYW'(1);
                mt = '0;
            end
            default:
            begin
                if (code_reg inside {[CH_PRINT_LO:CH_PRINT_HI]})
                begin
                    put_wr = 1'b1;
                    xt     = xt + TXW'(1);
                    mt     = (mod_reg == MW'(TAB_STOP - 1)) ? '0 : mod_reg + MW'(1);
                end
            end
        endcase
        // wrap at the right edge
        if (xt >= TXW'(COLS))
        begin
            xt = '0;
            yt = yt + TYW'(1);
            mt = '0;
        end
        scroll = (yt == TYW'(ROWS));
    end

    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        mod_next       = mod_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.exec && func_reg == FUNC_PUT)
        begin
            x_next   = XW'(xt);
            y_next   = scroll ? YW'(ROWS - 1) : YW'(yt);
            mod_next = mt;
        end
        else if (cmd.exec && func_reg == FUNC_CLEAR)
        begin
            x_next   = '0;
            y_next   = '0;
            mod_next = '0;
        end
        if (cmd.copy)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
        else if (cmd.fill)
        begin
            cnt_next = st.cell_last ? '0 : cnt_reg + AW'(1);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            mod_reg       <= '0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            mod_reg       <= mod_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= cmd.copy;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FG:  fg_reg <= cfg_wdata;
                    CFG_BG:  bg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= cnt_reg;
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            code_reg <= s_tdata[7:0];
            rrow_reg <= s_tdata[12:8];
            rcol_reg <= s_tdata[19:13];
        end
        if (cmd.exec)
        begin
            cell_reg     <= '0;
            scrolled_reg <= (func_reg == FUNC_PUT) && scroll;
        end
        else if (cmd.capture)
        begin
            cell_reg <= ram_rdata;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {scrolled_reg, cell_reg, 11'(y_reg * COLS + x_reg),
                             5'(y_reg), 7'(x_reg)};
        end
    end

    // Write port: pending copy beats a fill; a fill beats a character
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {bg_reg, fg_reg, code_reg};
        if (wr_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.fill)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = cmd.init ? RESET_CELL : blank;
        end
        else if (cmd.exec && func_reg == FUNC_PUT && put_wr)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = cmd.copy ? AW'(cnt_reg + COLS) : cell_addr;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (NCELL)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign st.func      = func_reg;
    assign st.rd_ok     = rd_ok;
    assign st.scroll    = scroll;
    assign st.copy_last = (cnt_reg == AW'(SPAN - 1));
    assign st.cell_last = (cnt_reg == AW'(NCELL - 1));
    assign st.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// File: design/tcw_ctrl.sv
// Controller state machine: sequences each item and the RAM sweeps.
// Depends on tcw_pkg; drives tcw_dp through the command struct.
module tcw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tcw_pkg::tcw_status_t st,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EXEC  = 9'b000000100,
        S_READ  = 9'b000001000,
        S_COPY  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_BLANK = 9'b001000000,
        S_FILL  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.fill = 1'b1;
                cmd.init = 1'b1;
                if (st.cell_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (st.func)
                    FUNC_PUT:   state_next = st.scroll ? S_COPY : S_DONE;
                    FUNC_CLEAR: state_next = S_FILL;
                    FUNC_READ:  state_next = st.rd_ok ? S_READ : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_COPY:
            begin
                // move each row up one row, one cell a cycle
                cmd.copy = 1'b1;
                if (st.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_BLANK;
            end
            S_BLANK, S_FILL:
            begin
                cmd.fill = 1'b1;
                if (st.cell_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
